>>> sv/cpr_pkg.sv
// cpr_pkg: types and constants used by the packet ring top level
// depends on nothing
`timescale 1ns / 1ps
package cpr_pkg;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_INSPECT = 2'd1,
    ACT_READ    = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_TAKEN      = 4'd0,
    ST_COMMITTED  = 4'd1,
    ST_BUSY       = 4'd2,
    ST_TOO_LONG   = 4'd3,
    ST_BAD_MODE   = 4'd4,
    ST_EMPTY      = 4'd5,
    ST_DROP_LEN   = 4'd6,
    ST_DROP_MODE  = 4'd7,
    ST_DROP_CRC   = 4'd8,
    ST_READY      = 4'd9,
    ST_READ       = 4'd10,
    ST_BAD_OFFSET = 4'd11,
    ST_RELEASED   = 4'd12,
    ST_STOPPED    = 4'd13
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_EXEC,
    S_CRC,
    S_CRC_END,
    S_DATA,
    S_OUT
  } state_t;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  MODE_STOP = 8'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        last;
    logic [7:0]  mode;
    logic [7:0]  gen_id;
    logic [9:0]  offset;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [10:0] length;
    logic [7:0]  packet_mode;
    logic [7:0]  packet_gen;
    logic [7:0]  read_byte;
    logic [15:0] checksum;
    logic [31:0] packets_done;
    logic        stopped;
  } out_item_t;

  typedef struct packed {
    logic [10:0] len;
    logic [7:0]  mode;
    logic [7:0]  gen;
    logic [15:0] crc;
  } hdr_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

>>> sv/cpr_ram.sv
// cpr_ram: generic single port write, single port read ram with registered read
// depends on nothing
`timescale 1ns / 1ps
module cpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> sv/crc_checked_packet_ring.sv
// crc_checked_packet_ring: top level, request sequencer around header and payload rams
// depends on cpr_pkg and cpr_ram
`timescale 1ns / 1ps
// One request in, one result out. A push, a release, an empty or rejected request and a
// read at a bad offset pass through accept, header read, update and result. A read that
// hits adds a payload read before the result. An inspect that passes the header checks
// recomputes the crc one byte per cycle from the payload ram and compares it before the
// result. A stalled result is held in place. Slot headers live in a ram and are zeroed by
// a sweep over every slot after reset, during which no request is taken. The result sits
// in an output register, and the next request is taken once it has been delivered.
module crc_checked_packet_ring #(
  parameter int SLOTS       = 64,
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cpr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cpr_pkg::out_item_t out_data
);
  import cpr_pkg::*;

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int AW = $clog2(SLOTS * MAX_PAYLOAD);
  localparam int HW = $bits(hdr_t);

  state_t state, state_next;
  in_item_t req;
  logic [SW-1:0] head_index, tail_index, clr_idx;
  logic clearing;
  logic [CW-1:0] push_count;
  logic [15:0] push_crc;
  logic f_open, f_long, f_busy;
  logic [31:0] done_count;
  logic stop_seen;
  logic [10:0] crc_cnt;
  logic [15:0] crc_acc;
  out_item_t res;

  logic          f_open_next, f_long_next, f_busy_next;
  logic [CW-1:0] push_count_next;
  logic [15:0]   push_crc_next;
  logic [SW-1:0] head_next, tail_next;
  logic [31:0]   done_next;
  logic          stop_next;
  out_item_t     res_next;

  logic          h_we;
  logic [SW-1:0] h_waddr, h_raddr;
  hdr_t          h_wdata, h_rdata, hdr;
  logic          p_we;
  logic [AW-1:0] p_waddr, p_raddr;
  logic [7:0]    p_wdata, p_rdata;

  cpr_ram #(.WIDTH(HW), .DEPTH(SLOTS)) u_hdr (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );
  cpr_ram #(.WIDTH(8), .DEPTH(SLOTS * MAX_PAYLOAD)) u_pay (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  function automatic logic [AW-1:0] paddr(logic [SW-1:0] s, logic [10:0] o);
    return AW'(s * MAX_PAYLOAD) + AW'(o);
  endfunction

  function automatic logic [SW-1:0] nxt(logic [SW-1:0] i);
    return (32'(i) + 1 >= SLOTS) ? '0 : i + 1'b1;
  endfunction

  assign in_stall  = clearing || (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = res;

  logic is_push;
  logic open_now, busy_now, long_now, take_now;
  logic [CW-1:0] cnt_new;
  logic [15:0] crc_new;
  logic len_bad, mode_bad;
  assign is_push  = (req.action == ACT_PUSH);
  assign len_bad  = hdr.len > 11'(MAX_PAYLOAD);
  assign mode_bad = hdr.mode > MODE_STOP;

  // push decisions, valid in S_EXEC
  always_comb begin
    open_now = f_open || f_busy || f_long;
    busy_now = f_busy || (!open_now && hdr.len != '0);
    long_now = !busy_now && (f_long || (open_now && push_count >= CW'(MAX_PAYLOAD)));
    take_now = !busy_now && !long_now;
    cnt_new  = open_now ? push_count : '0;
    crc_new  = open_now ? push_crc : CRC_INIT;
    if (take_now) begin
      crc_new = crc_byte(crc_new, req.data_byte);
      cnt_new = cnt_new + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_valid && !in_stall) state_next = S_HDR;
      S_HDR:     state_next = S_EXEC;
      S_EXEC: begin
        if (!is_push && hdr.len != '0 && req.action == ACT_INSPECT &&
            !len_bad && !mode_bad) state_next = S_CRC;
        else if (!is_push && hdr.len != '0 && req.action == ACT_READ &&
                 11'(req.offset) < hdr.len && 11'(req.offset) < 11'(MAX_PAYLOAD))
          state_next = S_DATA;
        else state_next = S_OUT;
      end
      S_CRC:     if (crc_cnt >= hdr.len) state_next = S_CRC_END;
      S_CRC_END: state_next = S_OUT;
      S_DATA:    state_next = S_OUT;
      S_OUT:     if (!out_stall) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // ram ports
  always_comb begin
    h_we = 1'b0; h_waddr = tail_index; h_wdata = '0;
    h_raddr = (in_data.action == ACT_PUSH) ? head_index : tail_index;
    p_we = 1'b0; p_waddr = paddr(head_index, 11'(push_count)); p_wdata = req.data_byte;
    p_raddr = paddr(tail_index, crc_cnt);
    if (clearing) begin
      h_we = 1'b1; h_waddr = clr_idx;
    end else if (state == S_EXEC) begin
      if (is_push) begin
        p_we = take_now;
        p_waddr = paddr(head_index, 11'(cnt_new - 1'b1));
        if (req.last && take_now && req.mode <= MODE_STOP) begin
          h_we = 1'b1; h_waddr = head_index;
          h_wdata = '{len: 11'(cnt_new), mode: req.mode, gen: req.gen_id, crc: crc_new};
        end
      end else if (hdr.len != '0) begin
        if (req.action == ACT_RELEASE ||
            (req.action == ACT_INSPECT && (len_bad || mode_bad))) h_we = 1'b1;
        p_raddr = paddr(tail_index, 11'(req.offset));
      end
    end else if (state == S_CRC_END && crc_acc != hdr.crc) begin
      h_we = 1'b1;
    end
  end

  // result and ring state updates
  always_comb begin
    res_next = res;
    head_next = head_index; tail_next = tail_index;
    f_open_next = f_open; f_long_next = f_long; f_busy_next = f_busy;
    push_count_next = push_count; push_crc_next = push_crc;
    done_next = done_count; stop_next = stop_seen;
    case (state)
      S_EXEC: begin
        res_next = '0;
        res_next.packets_done = done_count; res_next.stopped = stop_seen;
        if (is_push) begin
          res_next.status = busy_now ? ST_BUSY : long_now ? ST_TOO_LONG : ST_TAKEN;
          if (req.last) begin
            f_open_next = 1'b0; f_busy_next = 1'b0; f_long_next = 1'b0;
            push_count_next = '0; push_crc_next = CRC_INIT;
            if (take_now) begin
              if (req.mode > MODE_STOP) res_next.status = ST_BAD_MODE;
              else begin
                res_next.status = ST_COMMITTED;
                res_next.length = 11'(cnt_new); res_next.packet_mode = req.mode;
                res_next.packet_gen = req.gen_id; res_next.checksum = crc_new;
                head_next = nxt(head_index);
              end
            end
          end else begin
            f_open_next = !busy_now; f_busy_next = busy_now; f_long_next = long_now;
            push_count_next = cnt_new; push_crc_next = crc_new;
          end
        end else if (hdr.len == '0) begin
          res_next.status = ST_EMPTY;
        end else begin
          res_next.length = hdr.len; res_next.packet_mode = hdr.mode;
          res_next.packet_gen = hdr.gen; res_next.checksum = hdr.crc;
          case (req.action)
            ACT_INSPECT: begin
              if (len_bad || mode_bad) begin
                res_next.status = len_bad ? ST_DROP_LEN : ST_DROP_MODE;
                tail_next = nxt(tail_index);
              end
            end
            ACT_READ: res_next.status = ST_BAD_OFFSET;
            ACT_RELEASE: begin
              tail_next = nxt(tail_index);
              if (len_bad) res_next.status = ST_DROP_LEN;
              else if (mode_bad) res_next.status = ST_DROP_MODE;
              else if (hdr.mode == MODE_STOP) begin
                res_next.status = ST_STOPPED; stop_next = 1'b1; res_next.stopped = 1'b1;
              end else begin
                res_next.status = ST_RELEASED;
                done_next = done_count + 1'b1;
                res_next.packets_done = done_count + 1'b1;
              end
            end
            default: res_next.status = ST_EMPTY;
          endcase
        end
      end
      S_CRC_END: begin
        res_next.status = (crc_acc == hdr.crc) ? ST_READY : ST_DROP_CRC;
        if (crc_acc != hdr.crc) tail_next = nxt(tail_index);
      end
      S_DATA: begin
        res_next.status = ST_READ; res_next.read_byte = p_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; clearing <= 1'b1; clr_idx <= '0;
      head_index <= '0; tail_index <= '0;
      push_count <= '0; push_crc <= CRC_INIT;
      f_open <= 1'b0; f_long <= 1'b0; f_busy <= 1'b0;
      done_count <= '0; stop_seen <= 1'b0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_idx <= nxt(clr_idx);
        if (32'(clr_idx) == SLOTS - 1) clearing <= 1'b0;
      end
      if (state == S_IDLE && in_valid && !in_stall) req <= in_data;
      if (state == S_HDR) begin
        hdr <= h_rdata;
        crc_cnt <= '0; crc_acc <= CRC_INIT;
      end
      if (state == S_CRC) begin
        if (crc_cnt != '0) crc_acc <= crc_byte(crc_acc, p_rdata);
        crc_cnt <= crc_cnt + 1'b1;
      end
      res <= res_next;
      head_index <= head_next; tail_index <= tail_next;
      f_open <= f_open_next; f_long <= f_long_next; f_busy <= f_busy_next;
      push_count <= push_count_next; push_crc <= push_crc_next;
      done_count <= done_next; stop_seen <= stop_next;
    end
  end
endmodule
